/* sv/gwr_pkg.sv */
// Package for the grid wall raycaster: field widths, fixed-point constants,
// register indexes and the controller state type. No dependencies.
package gwr_pkg;

   localparam int MAP_SIDE_DEFAULT = 64;
   localparam int MAX_STEPS = 32;
   localparam int ANGLE_BITS = 12;

   localparam int CELL_W = 6;
   localparam int VALUE_W = 8;
   localparam int ANGLE_W = 12;
   localparam int POS_W = 14;
   localparam int DIM_W = 7;
   localparam int DIST_W = 16;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 14;

   localparam logic [15:0] POLY_A = 16'd51472;
   localparam logic [15:0] POLY_B = 16'd21077;
   localparam logic [15:0] POLY_C = 16'd2373;

   localparam logic [CSR_IDX_W-1:0] CSR_PLAYER_X = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PLAYER_Y = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAP_WIDTH = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MAP_HEIGHT = 3'd3;

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_CAST = 1'b1;

   typedef enum logic [17:0] {
      S_CLEAR  = 18'h00001,
      S_IDLE   = 18'h00002,
      S_T1     = 18'h00004,
      S_T2     = 18'h00008,
      S_T3     = 18'h00010,
      S_T4     = 18'h00020,
      S_T5     = 18'h00040,
      S_MSETUP = 18'h00080,
      S_DLOAD  = 18'h00100,
      S_DIV    = 18'h00200,
      S_STEP   = 18'h00400,
      S_TEST   = 18'h00800,
      S_SQ1    = 18'h01000,
      S_SQ2    = 18'h02000,
      S_SQ3    = 18'h04000,
      S_SQRT   = 18'h08000,
      S_MEND   = 18'h10000,
      S_OUT    = 18'h20000
   } state_type;

endpackage

/* sv/gwr_req_if.sv */
// Request channel of the raycaster: valid/ready plus a write or cast item.
// Depends on gwr_pkg for field widths.
interface gwr_req_if;
   import gwr_pkg::*;
   logic                 valid;
   logic                 ready;
   logic                 cmd;
   logic [CELL_W-1:0]    cell_x;
   logic [CELL_W-1:0]    cell_y;
   logic [VALUE_W-1:0]   cell_value;
   logic [ANGLE_W-1:0]   ray_angle;
   modport source (output valid, cmd, cell_x, cell_y, cell_value, ray_angle, input ready);
   modport sink (input valid, cmd, cell_x, cell_y, cell_value, ray_angle, output ready);
endinterface

/* sv/gwr_rsp_if.sv */
// Response channel of the raycaster: valid/ready plus one cast result.
// Depends on gwr_pkg for field widths.
interface gwr_rsp_if;
   import gwr_pkg::*;
   logic                 valid;
   logic                 ready;
   logic                 hit;
   logic [DIST_W-1:0]    distance;
   logic [VALUE_W-1:0]   tile_fraction;
   logic [VALUE_W-1:0]   wall_type;
   logic                 hit_x_wall;
   modport source (output valid, hit, distance, tile_fraction, wall_type, hit_x_wall,
                   input ready);
   modport sink (input valid, hit, distance, tile_fraction, wall_type, hit_x_wall,
                 output ready);
endinterface

/* sv/grid_wall_raycaster.sv */
// Grid wall raycaster: tile map memory, sine/cosine polynomial, two grid
// line marches with an iterative divider and an iterative square root.
// Depends on gwr_pkg, gwr_req_if and gwr_rsp_if.
// A write transaction goes straight into the map from the idle state. A cast computes sine and
// cosine, then per march runs the divider, steps up to 32 grid lines, takes the square root for
// the distance on a hit and finishes (an axis-parallel march goes straight to its end), then outputs.
// One cast is in flight at a time; a finished result waits in the output register.
// After reset the map is swept to zero, one cell per cycle.
module grid_wall_raycaster #(
   parameter int MAP_SIDE = gwr_pkg::MAP_SIDE_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   gwr_req_if.sink                              req_chan,
   gwr_rsp_if.source                            rsp_chan,
   input  logic                                 csr_we,
   input  logic [gwr_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [gwr_pkg::CSR_DATA_W-1:0]       csr_wdata
);
   import gwr_pkg::*;

   localparam int AW = (MAP_SIDE > 1) ? $clog2(MAP_SIDE) : 1;
   localparam int DEPTH = MAP_SIDE * MAP_SIDE;
   localparam int MW = $clog2(DEPTH);
   localparam int KW = $clog2(MAX_STEPS + 1);

   logic [VALUE_W-1:0] map_mem [DEPTH];
   logic [VALUE_W-1:0] mem_rdata_ff;
   logic               mem_we;
   logic [MW-1:0]      mem_waddr, mem_raddr;
   logic [VALUE_W-1:0] mem_wdata;

   state_type state_ff, state_in;
   logic [MW-1:0]    clr_ff, clr_in;
   logic [POS_W-1:0] px_ff, py_ff;
   logic [DIM_W-1:0] mw_ff, mh_ff;
   logic [15:0] phase_ff, phase_in;
   logic        tsel_ff, tsel_in;
   logic [15:0] t2_ff, t2_in;
   logic [31:0] prod_ff, prod_in;
   logic [15:0] sinm_ff, sinm_in, cosm_ff, cosm_in;
   logic        sinn_ff, sinn_in, cosn_ff, cosn_in;
   logic        mv_ff, mv_in;
   logic signed [8:0] cellm_ff, cellm_in;
   logic [14:0] off_ff, off_in;
   logic [KW-1:0] k_ff, k_in;
   logic [31:0] q_ff, q_in;
   logic [15:0] r_ff, r_in;
   logic [23:0] qs_ff, qs_in;
   logic [15:0] rs_ff, rs_in;
   logic [23:0] dnum_ff, dnum_in;
   logic [15:0] drem_ff, drem_in;
   logic [4:0]  dcnt_ff, dcnt_in;
   logic        dpass_ff, dpass_in;
   logic [7:0]  sfrac_ff, sfrac_in;
   logic        mhit_ff, mhit_in;
   logic [15:0] mdist_ff, mdist_in;
   logic [7:0]  mfrac_ff, mfrac_in, mtype_ff, mtype_in;
   logic        hh_ff, hh_in;
   logic [15:0] hd_ff, hd_in;
   logic [7:0]  hf_ff, hf_in, ht_ff, ht_in;
   logic [29:0] acc_ff, acc_in, sqv_ff, sqv_in, sqr_ff, sqr_in, sqb_ff, sqb_in;
   logic        ov_ff, ov_in, ohit_ff, ohit_in, oxw_ff, oxw_in;
   logic [15:0] odist_ff, odist_in;
   logic [7:0]  ofrac_ff, ofrac_in, otype_ff, otype_in;

   logic [15:0] ph, arg, mul_a, mul_b, dmm, dsm;
   logic [14:0] t15;
   logic [16:0] sraw;
   logic [POS_W-1:0] m0, s0;
   logic        dmn, dsn;
   logic [8:0]  weff, heff, off0;
   logic [16:0] trial;
   logic        ge;
   logic [33:0] side;
   logic [23:0] cells;
   logic        oob;
   logic [AW-1:0] col_idx, row_idx;
   logic [16:0] rsum;
   logic [29:0] sq_t;
   logic        mirror, vwin, acc_req, wr_ok;

   assign req_chan.ready = (state_ff == S_IDLE);
   assign acc_req = req_chan.valid && req_chan.ready;
   assign rsp_chan.valid = ov_ff;
   assign rsp_chan.hit = ohit_ff;
   assign rsp_chan.distance = odist_ff;
   assign rsp_chan.tile_fraction = ofrac_ff;
   assign rsp_chan.wall_type = otype_ff;
   assign rsp_chan.hit_x_wall = oxw_ff;

   always_comb begin
      ph = phase_ff + (tsel_ff ? 16'h4000 : 16'h0000);
      t15 = {ph[13:0], 1'b0};
      arg = ph[14] ? 16'(17'd32768 - {2'b00, t15}) : {1'b0, t15};
      sraw = prod_ff[31:15];
      m0 = mv_ff ? px_ff : py_ff;
      s0 = mv_ff ? py_ff : px_ff;
      dmm = mv_ff ? cosm_ff : sinm_ff;
      dmn = mv_ff ? cosn_ff : sinn_ff;
      dsm = mv_ff ? sinm_ff : cosm_ff;
      dsn = mv_ff ? sinn_ff : cosn_ff;
      weff = ({2'b00, mw_ff} > 9'(MAP_SIDE)) ? 9'(MAP_SIDE) : {2'b00, mw_ff};
      heff = ({2'b00, mh_ff} > 9'(MAP_SIDE)) ? 9'(MAP_SIDE) : {2'b00, mh_ff};
      off0 = dmn ? {1'b0, m0[7:0]} : 9'(9'd256 - {1'b0, m0[7:0]});
      trial = {drem_ff, dnum_ff[23]};
      ge = trial >= {1'b0, dmm};
      side = dsn ? ({20'b0, s0} - {2'b00, q_ff}) : ({20'b0, s0} + {2'b00, q_ff});
      cells = side[31:8];
      if (mv_ff) begin
         oob = side[33] || cellm_ff[8] || ({1'b0, cellm_ff[7:0]} >= weff) ||
               (cells >= {15'b0, heff});
         col_idx = cellm_ff[AW-1:0];
         row_idx = cells[AW-1:0];
      end else begin
         oob = side[33] || cellm_ff[8] || ({1'b0, cellm_ff[7:0]} >= heff) ||
               (cells >= {15'b0, weff});
         col_idx = cells[AW-1:0];
         row_idx = cellm_ff[AW-1:0];
      end
      rsum = {1'b0, r_ff} + {1'b0, rs_ff};
      sq_t = sqr_ff + sqb_ff;
      mirror = mv_ff ? dmn : !dmn;
      vwin = mhit_ff && (!hh_ff || (mdist_ff < hd_ff));
      wr_ok = ({3'b000, req_chan.cell_x} < 9'(MAP_SIDE)) &&
              ({3'b000, req_chan.cell_y} < 9'(MAP_SIDE));
   end

   always_comb begin
      mul_a = arg;
      mul_b = arg;
      unique case (state_ff)
         S_T2: begin
            mul_a = POLY_C;
            mul_b = prod_ff[30:15];
         end
         S_T3: begin
            mul_a = POLY_B - prod_ff[30:15];
            mul_b = t2_ff;
         end
         S_T4: begin
            mul_a = POLY_A - prod_ff[30:15];
            mul_b = arg;
         end
         S_MSETUP: begin
            mul_a = {7'b0, off0};
            mul_b = dsm;
         end
         S_SQ1: begin
            mul_a = {1'b0, off_ff};
            mul_b = {1'b0, off_ff};
         end
         S_SQ2: begin
            mul_a = q_ff[15:0];
            mul_b = q_ff[15:0];
         end
         default: begin
            mul_a = arg;
            mul_b = arg;
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      clr_in = clr_ff;
      phase_in = phase_ff;
      tsel_in = tsel_ff;
      t2_in = t2_ff;
      prod_in = mul_a * mul_b;
      sinm_in = sinm_ff; sinn_in = sinn_ff;
      cosm_in = cosm_ff; cosn_in = cosn_ff;
      mv_in = mv_ff;
      cellm_in = cellm_ff;
      off_in = off_ff;
      k_in = k_ff;
      q_in = q_ff; r_in = r_ff;
      qs_in = qs_ff; rs_in = rs_ff;
      dnum_in = dnum_ff; drem_in = drem_ff;
      dcnt_in = dcnt_ff; dpass_in = dpass_ff;
      sfrac_in = sfrac_ff;
      mhit_in = mhit_ff; mdist_in = mdist_ff;
      mfrac_in = mfrac_ff; mtype_in = mtype_ff;
      hh_in = hh_ff; hd_in = hd_ff; hf_in = hf_ff; ht_in = ht_ff;
      acc_in = acc_ff; sqv_in = sqv_ff; sqr_in = sqr_ff; sqb_in = sqb_ff;
      ov_in = ov_ff && !rsp_chan.ready;
      ohit_in = ohit_ff; odist_in = odist_ff; ofrac_in = ofrac_ff;
      otype_in = otype_ff; oxw_in = oxw_ff;
      mem_we = 1'b0;
      mem_waddr = clr_ff;
      mem_wdata = '0;
      mem_raddr = MW'(row_idx) * MW'(MAP_SIDE) + MW'(col_idx);
      unique case (state_ff)
         S_CLEAR: begin
            mem_we = 1'b1;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == MW'(DEPTH - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (acc_req) begin
               if (req_chan.cmd == CMD_WRITE) begin
                  mem_we = wr_ok;
                  mem_waddr = MW'(req_chan.cell_y) * MW'(MAP_SIDE) + MW'(req_chan.cell_x);
                  mem_wdata = req_chan.cell_value;
               end else begin
                  phase_in = 16'(req_chan.ray_angle[ANGLE_BITS-1:0]) << (16 - ANGLE_BITS);
                  tsel_in = 1'b0;
                  state_in = S_T1;
               end
            end
         end
         S_T1: state_in = S_T2;
         S_T2: begin
            t2_in = prod_ff[30:15];
            state_in = S_T3;
         end
         S_T3: state_in = S_T4;
         S_T4: state_in = S_T5;
         S_T5: begin
            if (tsel_ff) begin
               cosm_in = (sraw > 17'd32768) ? 16'h8000 : sraw[15:0];
               cosn_in = ph[15];
               mv_in = 1'b0;
               state_in = S_MSETUP;
            end else begin
               sinm_in = (sraw > 17'd32768) ? 16'h8000 : sraw[15:0];
               sinn_in = ph[15];
               tsel_in = 1'b1;
               state_in = S_T1;
            end
         end
         S_MSETUP: begin
            mhit_in = 1'b0;
            k_in = '0;
            dpass_in = 1'b0;
            off_in = {6'b0, off0};
            cellm_in = dmn ? $signed({3'b000, m0[13:8]}) - 9'sd1
                           : $signed({3'b000, m0[13:8]}) + 9'sd1;
            state_in = (dmm == 16'd0) ? S_MEND : S_DLOAD;
         end
         S_DLOAD: begin
            dnum_in = dpass_ff ? {dsm, 8'b0} : prod_ff[23:0];
            drem_in = '0;
            dcnt_in = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            drem_in = ge ? 16'(trial - {1'b0, dmm}) : trial[15:0];
            dnum_in = {dnum_ff[22:0], ge};
            dcnt_in = dcnt_ff + 1'b1;
            if (dcnt_ff == 5'd23) begin
               if (dpass_ff) begin
                  qs_in = {dnum_ff[22:0], ge};
                  rs_in = drem_in;
                  state_in = S_STEP;
               end else begin
                  q_in = {8'b0, dnum_ff[22:0], ge};
                  r_in = drem_in;
                  dpass_in = 1'b1;
                  state_in = S_DLOAD;
               end
            end
         end
         S_STEP: begin
            sfrac_in = side[7:0];
            state_in = oob ? S_MEND : S_TEST;
         end
         S_TEST: begin
            if (mem_rdata_ff != '0) begin
               mhit_in = 1'b1;
               mtype_in = mem_rdata_ff;
               mfrac_in = (mirror) ? ((sfrac_ff == 8'd0) ? 8'hFF : 8'(9'd256 - {1'b0, sfrac_ff}))
                                   : sfrac_ff;
               state_in = S_SQ1;
            end else begin
               if (rsum >= {1'b0, dmm}) begin
                  r_in = 16'(rsum - {1'b0, dmm});
                  q_in = q_ff + {8'b0, qs_ff} + 32'd1;
               end else begin
                  r_in = rsum[15:0];
                  q_in = q_ff + {8'b0, qs_ff};
               end
               off_in = off_ff + 15'd256;
               cellm_in = dmn ? cellm_ff - 9'sd1 : cellm_ff + 9'sd1;
               k_in = k_ff + 1'b1;
               state_in = (k_ff == KW'(MAX_STEPS - 1)) ? S_MEND : S_STEP;
            end
         end
         S_SQ1: state_in = S_SQ2;
         S_SQ2: begin
            acc_in = prod_ff[29:0];
            state_in = S_SQ3;
         end
         S_SQ3: begin
            sqv_in = acc_ff + prod_ff[29:0];
            sqr_in = '0;
            sqb_in = 30'h1000_0000;
            state_in = S_SQRT;
         end
         S_SQRT: begin
            if (sqv_ff >= sq_t) begin
               sqv_in = sqv_ff - sq_t;
               sqr_in = (sqr_ff >> 1) + sqb_ff;
            end else begin
               sqr_in = sqr_ff >> 1;
            end
            sqb_in = sqb_ff >> 2;
            if (sqb_ff == 30'd1) begin
               mdist_in = sqr_in[15:0];
               state_in = S_MEND;
            end
         end
         S_MEND: begin
            if (mv_ff) begin
               state_in = S_OUT;
            end else begin
               hh_in = mhit_ff;
               hd_in = mdist_ff;
               hf_in = mfrac_ff;
               ht_in = mtype_ff;
               mv_in = 1'b1;
               state_in = S_MSETUP;
            end
         end
         S_OUT: begin
            if (!ov_ff || rsp_chan.ready) begin
               ov_in = 1'b1;
               if (vwin) begin
                  ohit_in = 1'b1; odist_in = mdist_ff; ofrac_in = mfrac_ff;
                  otype_in = mtype_ff; oxw_in = 1'b1;
               end else if (hh_ff) begin
                  ohit_in = 1'b1; odist_in = hd_ff; ofrac_in = hf_ff;
                  otype_in = ht_ff; oxw_in = 1'b0;
               end else begin
                  ohit_in = 1'b0; odist_in = 16'hFFFF; ofrac_in = '0;
                  otype_in = '0; oxw_in = 1'b0;
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         map_mem[mem_waddr] <= mem_wdata;
      end
      mem_rdata_ff <= map_mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff <= '0;
         ov_ff <= 1'b0;
         px_ff <= 14'd128;
         py_ff <= 14'd128;
         mw_ff <= 7'd64;
         mh_ff <= 7'd64;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         ov_ff <= ov_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_PLAYER_X: px_ff <= csr_wdata[POS_W-1:0];
               CSR_PLAYER_Y: py_ff <= csr_wdata[POS_W-1:0];
               CSR_MAP_WIDTH: mw_ff <= csr_wdata[DIM_W-1:0];
               CSR_MAP_HEIGHT: mh_ff <= csr_wdata[DIM_W-1:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      phase_ff <= phase_in; tsel_ff <= tsel_in; t2_ff <= t2_in; prod_ff <= prod_in;
      sinm_ff <= sinm_in; sinn_ff <= sinn_in; cosm_ff <= cosm_in; cosn_ff <= cosn_in;
      mv_ff <= mv_in; cellm_ff <= cellm_in; off_ff <= off_in; k_ff <= k_in;
      q_ff <= q_in; r_ff <= r_in; qs_ff <= qs_in; rs_ff <= rs_in;
      dnum_ff <= dnum_in; drem_ff <= drem_in; dcnt_ff <= dcnt_in; dpass_ff <= dpass_in;
      sfrac_ff <= sfrac_in;
      mhit_ff <= mhit_in; mdist_ff <= mdist_in; mfrac_ff <= mfrac_in; mtype_ff <= mtype_in;
      hh_ff <= hh_in; hd_ff <= hd_in; hf_ff <= hf_in; ht_ff <= ht_in;
      acc_ff <= acc_in; sqv_ff <= sqv_in; sqr_ff <= sqr_in; sqb_ff <= sqb_in;
      ohit_ff <= ohit_in; odist_ff <= odist_in; ofrac_ff <= ofrac_in;
      otype_ff <= otype_in; oxw_ff <= oxw_in;
   end

`ifndef NO_ASSERTIONS
   a_miss_fields: assert property (@(posedge clock) disable iff (reset)
      ov_ff && !ohit_ff |-> odist_ff == 16'hFFFF && ofrac_ff == '0 && otype_ff == '0 && !oxw_ff)
      else $error("miss result fields are not the no-hit pattern");
   a_hit_type: assert property (@(posedge clock) disable iff (reset)
      ov_ff && ohit_ff |-> otype_ff != '0 && !odist_ff[15])
      else $error("hit result carries an empty wall type or an oversized distance");
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_TEST |-> r_ff < dmm)
      else $error("step remainder is not below the divisor");
   a_clear_blocks: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CLEAR |-> !req_chan.ready && !ov_ff)
      else $error("transaction possible during the map clearing sweep");
`endif

endmodule
